/* rtl/sem_pkg.sv */
// Shared types and constants of the Sobel edge magnitude block.
`timescale 1ns / 1ps

package sem_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned FW_W       = 11;
    localparam int unsigned FH_W       = 12;
    localparam int unsigned MG_W       = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MARGIN = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_PAD   = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST   = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST  = 12'd480;
    localparam logic [MG_W-1:0] BORDER_MARGIN_RST = 4'd3;

    localparam int unsigned ABS_W  = 10;
    localparam int unsigned RAD_W  = 21;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    localparam int unsigned DIGITS_PER_ROUND = 4;
    localparam int unsigned ROUNDS           = 3;
    localparam int unsigned ROUND_CNT_W      = 2;
    localparam int unsigned ROOT_W           = 12;
    localparam int unsigned REM_W            = 13;
    localparam int unsigned RAD_PAD_W        = 24;

    localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

    typedef struct packed {
        logic [FW_W-1:0] frame_width;
        logic [FH_W-1:0] frame_height;
        logic [MG_W-1:0] border_margin;
    } t_cfg;

    typedef struct packed {
        logic [RAD_W-1:0] radicand;
        logic             last;
    } t_task;

endpackage

/* rtl/sem_front.sv */
// Front end: line stores, 3x3 window, position tracking and gradient squares.
`timescale 1ns / 1ps

module sem_front #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sem_pkg::t_cfg                 i_cfg,
    input  logic                          i_push,
    input  logic                          i_op,
    input  logic [sem_pkg::PIX_W-1:0]     i_pixel,
    output logic                          o_full,
    input  logic [sem_pkg::QCNT_W-1:0]    i_q_count,
    output logic                          o_task_push,
    output sem_pkg::t_task                o_task
);

    localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned EWW = (CW + 2 > 13) ? CW + 2 : 13;
    localparam int unsigned LW  = $clog2(MAX_WIDTH + 2);
    localparam int unsigned HW  = sem_pkg::FH_W + 1;
    localparam int unsigned PW  = sem_pkg::PIX_W;
    localparam int unsigned AW  = sem_pkg::ABS_W;
    localparam int unsigned OCW = sem_pkg::QCNT_W + 1;

    logic [PW-1:0] mem_upper  [MAX_WIDTH];
    logic [PW-1:0] mem_middle [MAX_WIDTH];

    logic                 r_clr_busy;
    logic [CW-1:0]        r_clr_addr;
    logic [CW-1:0]        r_in_col;
    logic [CW-1:0]        r_out_col;
    logic [sem_pkg::FH_W-1:0] r_out_row;
    logic [LW-1:0]        r_lag;
    logic [PW-1:0]        r_rd_upper;
    logic [PW-1:0]        r_rd_middle;

    logic                 r_b_valid;
    logic                 r_b_pixel;
    logic                 r_b_emit;
    logic                 r_b_compute;
    logic                 r_b_last;
    logic                 r_b_fwd;
    logic [CW-1:0]        r_b_col;
    logic [PW-1:0]        r_b_pix;
    logic [PW-1:0]        r_fwd_upper;
    logic [PW-1:0]        r_fwd_middle;
    logic [PW-1:0]        r_win [0:2][0:2];

    logic                 r_c_valid;
    logic                 r_c_last;
    logic [AW-1:0]        r_c_ax;
    logic [AW-1:0]        r_c_ay;

    logic [EWW-1:0]       eff_w;
    logic [HW-1:0]        eff_h;
    logic [sem_pkg::MG_W-1:0] eff_m;
    logic                 accept;
    logic                 is_pixel;
    logic                 lag_full;
    logic                 emit;
    logic                 border;
    logic                 in_col_wrap;
    logic                 out_col_wrap;
    logic                 out_row_wrap;
    logic                 fwd;
    logic [OCW-1:0]       occupancy;
    logic [PW-1:0]        top_b;
    logic [PW-1:0]        mid_b;
    logic [PW-1:0]        win_n [0:2][0:2];
    logic signed [11:0]   gx;
    logic signed [11:0]   gy;
    logic signed [11:0]   gx_abs;
    logic signed [11:0]   gy_abs;
    logic [2*AW-1:0]      sq_x;
    logic [2*AW-1:0]      sq_y;

    always_comb begin
        if (i_cfg.frame_width == '0) begin
            eff_w = EWW'(1);
        end else if (EWW'(i_cfg.frame_width) > EWW'(MAX_WIDTH)) begin
            eff_w = EWW'(MAX_WIDTH);
        end else begin
            eff_w = EWW'(i_cfg.frame_width);
        end
        eff_h = (i_cfg.frame_height == '0) ? HW'(1) : HW'(i_cfg.frame_height);
        eff_m = (i_cfg.border_margin == '0) ? 4'd1 : i_cfg.border_margin;
    end

    assign occupancy = OCW'(i_q_count) + OCW'(r_b_valid && r_b_emit) + OCW'(r_c_valid);
    assign o_full    = r_clr_busy || (occupancy >= OCW'(sem_pkg::QDEPTH));
    assign accept    = i_push && !o_full;
    assign is_pixel  = (i_op == sem_pkg::OP_PIXEL);

    assign lag_full     = EWW'(r_lag) >= eff_w + EWW'(1);
    assign emit         = is_pixel ? lag_full : (r_lag != '0);
    assign in_col_wrap  = EWW'(r_in_col) + EWW'(1) >= eff_w;
    assign out_col_wrap = EWW'(r_out_col) + EWW'(1) >= eff_w;
    assign out_row_wrap = HW'(r_out_row) + HW'(1) >= eff_h;
    assign border       = (HW'(r_out_row) < HW'(eff_m))
                       || (HW'(r_out_row) + HW'(eff_m) >= eff_h)
                       || (EWW'(r_out_col) < EWW'(eff_m))
                       || (EWW'(r_out_col) + EWW'(eff_m) >= eff_w);
    assign fwd          = r_b_valid && r_b_pixel && (r_b_col == r_in_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + CW'(1);
            if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_lag     <= '0;
        end else if (accept) begin
            if (is_pixel) begin
                r_in_col <= in_col_wrap ? '0 : r_in_col + CW'(1);
                if (!lag_full) begin
                    r_lag <= r_lag + LW'(1);
                end
            end else if (r_lag != '0) begin
                r_lag <= r_lag - LW'(1);
            end
            if (emit) begin
                if (out_col_wrap) begin
                    r_out_col <= '0;
                    r_out_row <= out_row_wrap ? '0 : r_out_row + sem_pkg::FH_W'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_upper  <= mem_upper[r_in_col];
        r_rd_middle <= mem_middle[r_in_col];
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_upper[r_clr_addr]  <= '0;
            mem_middle[r_clr_addr] <= '0;
        end else if (r_b_valid && r_b_pixel) begin
            mem_upper[r_b_col]  <= mid_b;
            mem_middle[r_b_col] <= r_b_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pixel    <= is_pixel;
            r_b_emit     <= emit;
            r_b_compute  <= is_pixel && !border;
            r_b_last     <= out_col_wrap && out_row_wrap;
            r_b_fwd      <= fwd;
            r_b_col      <= r_in_col;
            r_b_pix      <= i_pixel;
            r_fwd_upper  <= mid_b;
            r_fwd_middle <= r_b_pix;
        end
    end

    assign top_b = r_b_fwd ? r_fwd_upper  : r_rd_upper;
    assign mid_b = r_b_fwd ? r_fwd_middle : r_rd_middle;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_n[i][0] = r_win[i][1];
            win_n[i][1] = r_win[i][2];
        end
        win_n[0][2] = top_b;
        win_n[1][2] = mid_b;
        win_n[2][2] = r_b_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (r_b_valid && r_b_pixel) begin
            r_win <= win_n;
        end
    end

    always_comb begin
        gx = ($signed({4'b0, win_n[0][2]}) + ($signed({4'b0, win_n[1][2]}) <<< 1)
              + $signed({4'b0, win_n[2][2]}))
           - ($signed({4'b0, win_n[0][0]}) + ($signed({4'b0, win_n[1][0]}) <<< 1)
              + $signed({4'b0, win_n[2][0]}));
        gy = ($signed({4'b0, win_n[2][0]}) + ($signed({4'b0, win_n[2][1]}) <<< 1)
              + $signed({4'b0, win_n[2][2]}))
           - ($signed({4'b0, win_n[0][0]}) + ($signed({4'b0, win_n[0][1]}) <<< 1)
              + $signed({4'b0, win_n[0][2]}));
        gx_abs = gx[11] ? -gx : gx;
        gy_abs = gy[11] ? -gy : gy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid && r_b_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_last <= r_b_last;
        r_c_ax   <= r_b_compute ? gx_abs[AW-1:0] : '0;
        r_c_ay   <= r_b_compute ? gy_abs[AW-1:0] : '0;
    end

    assign sq_x = r_c_ax * r_c_ax;
    assign sq_y = r_c_ay * r_c_ay;

    assign o_task_push     = r_c_valid;
    assign o_task.radicand = sem_pkg::RAD_W'(sq_x) + sem_pkg::RAD_W'(sq_y);
    assign o_task.last     = r_c_last;

endmodule

/* rtl/sem_queue.sv */
// Short task queue between the front end and the square root unit.
`timescale 1ns / 1ps

module sem_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  sem_pkg::t_task             i_data,
    output logic [sem_pkg::QCNT_W-1:0] o_count,
    output logic                       o_valid,
    output sem_pkg::t_task             o_data,
    input  logic                       i_pop
);

    sem_pkg::t_task                 r_mem [sem_pkg::QDEPTH];
    logic [sem_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [sem_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [sem_pkg::QCNT_W-1:0]     r_count;
    logic                           do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_count = r_count;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + sem_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + sem_pkg::QPTR_W'(1);
            end
            r_count <= r_count + sem_pkg::QCNT_W'(i_push) - sem_pkg::QCNT_W'(do_pop);
        end
    end

endmodule

/* rtl/sem_back.sv */
// Back end: iterative integer square root, clamp and result register.
`timescale 1ns / 1ps

module sem_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_task_valid,
    input  sem_pkg::t_task            i_task,
    output logic                      o_task_pop,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic [sem_pkg::PIX_W-1:0] o_magnitude,
    output logic                      o_frame_end
);

    localparam int unsigned REMX_W = sem_pkg::REM_W + 2;
    localparam int unsigned TRL_W  = sem_pkg::ROOT_W + 1;

    logic                                r_busy;
    logic [sem_pkg::ROUND_CNT_W-1:0]     r_cnt;
    logic [sem_pkg::RAD_PAD_W-1:0]       r_rad;
    logic [sem_pkg::REM_W-1:0]           r_rem;
    logic [sem_pkg::ROOT_W-1:0]          r_root;
    logic                                r_last;
    logic                                r_out_valid;
    logic [sem_pkg::PIX_W-1:0]           r_out_mag;
    logic                                r_out_last;

    logic                                done;
    logic                                xfer;
    logic                                load;
    logic                                out_pop;
    logic [sem_pkg::RAD_PAD_W-1:0]       rad_t;
    logic [sem_pkg::REM_W-1:0]           rem_t;
    logic [sem_pkg::ROOT_W-1:0]          root_t;
    logic [REMX_W-1:0]                   rem_w;
    logic [TRL_W-1:0]                    trial;

    assign out_pop    = i_pop && r_out_valid;
    assign done       = r_busy && (r_cnt == '0);
    assign xfer       = done && (!r_out_valid || out_pop);
    assign load       = i_task_valid && (!r_busy || xfer);
    assign o_task_pop = load;

    always_comb begin
        rad_t  = r_rad;
        rem_t  = r_rem;
        root_t = r_root;
        rem_w  = '0;
        trial  = '0;
        for (int k = 0; k < sem_pkg::DIGITS_PER_ROUND; k++) begin
            root_t = {root_t[sem_pkg::ROOT_W-2:0], 1'b0};
            rem_w  = {rem_t, rad_t[sem_pkg::RAD_PAD_W-1 -: 2]};
            rad_t  = {rad_t[sem_pkg::RAD_PAD_W-3:0], 2'b00};
            trial  = {root_t, 1'b1};
            if (REMX_W'(trial) <= rem_w) begin
                rem_w     = rem_w - REMX_W'(trial);
                root_t[0] = 1'b1;
            end
            rem_t = rem_w[sem_pkg::REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= sem_pkg::ROUND_CNT_W'(sem_pkg::ROUNDS);
        end else if (xfer) begin
            r_busy <= 1'b0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_cnt <= r_cnt - sem_pkg::ROUND_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rad  <= sem_pkg::RAD_PAD_W'(i_task.radicand);
            r_rem  <= '0;
            r_root <= '0;
            r_last <= i_task.last;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rad  <= rad_t;
            r_rem  <= rem_t;
            r_root <= root_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (xfer) begin
            r_out_valid <= 1'b1;
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_out_mag  <= (r_root > sem_pkg::ROOT_W'(sem_pkg::MAG_MAX))
                        ? sem_pkg::MAG_MAX : r_root[sem_pkg::PIX_W-1:0];
            r_out_last <= r_last;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_magnitude = r_out_mag;
    assign o_frame_end = r_out_last;

endmodule

/* rtl/sobel_edge_magnitude.sv */
// Top level of the Sobel edge magnitude block with its configuration registers.
//
// Pixels enter in raster order and each result describes one centre position,
// lagging the input by one line plus one pixel; pad transactions drain the tail.
// The front end takes one transaction per clock while full is low, so pixels
// that produce no result flow at one per clock. Every result goes through the
// square root unit, which resolves four root digits per clock and works on one
// result at a time, taking the next task as it hands over the last root; a
// 4-entry queue lets the front end run ahead of it. After reset, full stays high
// while both line stores are cleared; configuration writes are taken at any time.
`timescale 1ns / 1ps

module sobel_edge_magnitude #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_op,
    input  logic [sem_pkg::PIX_W-1:0]         i_pixel,
    output logic                              empty,
    input  logic                              pop,
    output logic [sem_pkg::PIX_W-1:0]         o_magnitude,
    output logic                              o_frame_end,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    sem_pkg::t_cfg                  r_cfg;
    logic [sem_pkg::QCNT_W-1:0]     q_count;
    logic                           task_push;
    sem_pkg::t_task                 task_in;
    logic                           task_valid;
    sem_pkg::t_task                 task_out;
    logic                           task_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= sem_pkg::FRAME_WIDTH_RST;
            r_cfg.frame_height  <= sem_pkg::FRAME_HEIGHT_RST;
            r_cfg.border_margin <= sem_pkg::BORDER_MARGIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sem_pkg::CFG_FRAME_WIDTH: begin
                    r_cfg.frame_width <= i_cfg_data[sem_pkg::FW_W-1:0];
                end
                sem_pkg::CFG_FRAME_HEIGHT: begin
                    r_cfg.frame_height <= i_cfg_data[sem_pkg::FH_W-1:0];
                end
                sem_pkg::CFG_BORDER_MARGIN: begin
                    r_cfg.border_margin <= i_cfg_data[sem_pkg::MG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_op        (i_op),
        .i_pixel     (i_pixel),
        .o_full      (full),
        .i_q_count   (q_count),
        .o_task_push (task_push),
        .o_task      (task_in)
    );

    sem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (task_push),
        .i_data  (task_in),
        .o_count (q_count),
        .o_valid (task_valid),
        .o_data  (task_out),
        .i_pop   (task_pop)
    );

    sem_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (task_valid),
        .i_task       (task_out),
        .o_task_pop   (task_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_magnitude  (o_magnitude),
        .o_frame_end  (o_frame_end)
    );

endmodule

/* rtl/sem_checker.sv */
// Port-level checker of the Sobel edge magnitude block and its bind statement.
`timescale 1ns / 1ps

module sem_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic [sem_pkg::PIX_W-1:0] o_magnitude,
    input logic                      o_frame_end
);

    a_full_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("Input side accepts transactions while the line stores are cleared.");

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("A result is shown right after reset.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("A waiting result vanished without a pop.");

    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_magnitude) && $stable(o_frame_end))
        else $error("A waiting result changed before it was popped.");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_magnitude (o_magnitude),
    .o_frame_end (o_frame_end)
);
